FILE: sv/tsfs_pkg.sv
`default_nettype none
package tsfs_pkg;

  localparam int unsigned DistW  = 9;
  localparam int unsigned DutyW  = 5;
  localparam int unsigned TickW  = 6;
  localparam int unsigned PauseW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 9;

  localparam int unsigned SettleTicksDefault = 50;
  localparam int unsigned TrigTicksDefault   = 2;
  localparam logic [TickW-1:0] UnitTicks     = TickW'(2);

  localparam logic [PauseW-1:0] PauseNear = PauseW'(3);
  localparam logic [PauseW-1:0] PauseStd  = PauseW'(5);
  localparam logic [PauseW-1:0] PauseNone = PauseW'(0);

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegNearLimit   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegStopLimit   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegFollowLimit = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegDriveSpeed  = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegTurnSpeed   = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegRangeLimit  = CfgIdxW'(5);

  // sensor selector codes
  localparam logic [1:0] SelMiddle = 2'd0;
  localparam logic [1:0] SelLeft   = 2'd1;
  localparam logic [1:0] SelRight  = 2'd2;

  typedef struct packed {
    logic [DistW-1:0] near_limit;
    logic [DistW-1:0] stop_limit;
    logic [DistW-1:0] follow_limit;
    logic [DutyW-1:0] drive_speed;
    logic [DutyW-1:0] turn_speed;
    logic [DistW-1:0] range_limit;
  } cfg_t;

  typedef struct packed {
    logic echo_right;
    logic echo_left;
    logic echo_middle;
    logic pause_tick;
    logic fine_tick;
  } in_item_t;

  typedef struct packed {
    logic b_in2;
    logic b_in1;
    logic a_in2;
    logic a_in1;
    logic standby_n;
  } motor_t;

  typedef struct packed {
    motor_t            pins;
    logic [DutyW-1:0]  duty_a;
    logic [DutyW-1:0]  duty_b;
    logic [PauseW-1:0] pause;
  } drive_t;

  typedef struct packed {
    logic             decided;
    logic [DutyW-1:0] duty_b;
    logic [DutyW-1:0] duty_a;
    motor_t           pins;
    logic             trig_right;
    logic             trig_left;
    logic             trig_middle;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/tsfs_decide.sv
`default_nettype none
module tsfs_decide (
  input  wire tsfs_pkg::cfg_t                  cfg,
  input  wire logic [tsfs_pkg::DistW-1:0]      dist_m,
  input  wire logic [tsfs_pkg::DistW-1:0]      dist_l,
  input  wire logic [tsfs_pkg::DistW-1:0]      dist_r,
  input  wire tsfs_pkg::motor_t                pins_cur,
  input  wire logic [tsfs_pkg::DutyW-1:0]      duty_a_cur,
  input  wire logic [tsfs_pkg::DutyW-1:0]      duty_b_cur,
  output tsfs_pkg::drive_t                     drive
);

  tsfs_pkg::motor_t fwd_pins;
  tsfs_pkg::motor_t back_pins;
  tsfs_pkg::motor_t stop_pins;

  always_comb begin
    fwd_pins  = '{b_in2: 1'b1, b_in1: 1'b0, a_in2: 1'b0, a_in1: 1'b1, standby_n: 1'b1};
    back_pins = '{b_in2: 1'b0, b_in1: 1'b1, a_in2: 1'b1, a_in1: 1'b0, standby_n: 1'b1};
    stop_pins = pins_cur;
    stop_pins.standby_n = 1'b0;

    // stop keeps the duties and direction pins
    drive.pins   = stop_pins;
    drive.duty_a = duty_a_cur;
    drive.duty_b = duty_b_cur;
    drive.pause  = tsfs_pkg::PauseNone;

    if (dist_m < cfg.near_limit) begin
      drive.pins   = back_pins;
      drive.duty_a = cfg.drive_speed;
      drive.duty_b = cfg.drive_speed;
      drive.pause  = tsfs_pkg::PauseNear;
    end else if (dist_m < cfg.stop_limit) begin
      drive.pause  = tsfs_pkg::PauseStd;
    end else if (dist_m < cfg.follow_limit) begin
      drive.pins   = fwd_pins;
      drive.duty_a = cfg.drive_speed;
      drive.duty_b = cfg.drive_speed;
      drive.pause  = tsfs_pkg::PauseStd;
    end else if (dist_l < cfg.follow_limit && dist_r > cfg.follow_limit) begin
      drive.pins   = fwd_pins;
      drive.duty_a = '0;
      drive.duty_b = cfg.turn_speed;
      drive.pause  = tsfs_pkg::PauseStd;
    end else if (dist_l > cfg.follow_limit && dist_r < cfg.follow_limit) begin
      drive.pins   = fwd_pins;
      drive.duty_a = cfg.turn_speed;
      drive.duty_b = '0;
      drive.pause  = tsfs_pkg::PauseStd;
    end else if (dist_l < cfg.stop_limit && dist_r > cfg.follow_limit) begin
      drive.pins   = back_pins;
      drive.duty_a = cfg.turn_speed;
      drive.duty_b = '0;
      drive.pause  = tsfs_pkg::PauseStd;
    end else if (dist_l > cfg.follow_limit && dist_r < cfg.stop_limit) begin
      drive.pins   = back_pins;
      drive.duty_a = '0;
      drive.duty_b = cfg.turn_speed;
      drive.pause  = tsfs_pkg::PauseStd;
    end else if (dist_l > cfg.follow_limit && dist_r < cfg.follow_limit) begin
      drive.pins   = back_pins;
      drive.duty_a = cfg.drive_speed;
      drive.duty_b = cfg.drive_speed;
      drive.pause  = tsfs_pkg::PauseStd;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tsfs_core.sv
`default_nettype none
module tsfs_core #(
  parameter int unsigned SETTLE_TICKS = tsfs_pkg::SettleTicksDefault,
  parameter int unsigned TRIG_TICKS   = tsfs_pkg::TrigTicksDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire tsfs_pkg::in_item_t item,
  input  wire tsfs_pkg::cfg_t     cfg,
  output tsfs_pkg::res_t          res
);

  localparam logic [tsfs_pkg::TickW-1:0] TrigLim   = tsfs_pkg::TickW'(TRIG_TICKS);
  localparam logic [tsfs_pkg::TickW-1:0] SettleLim = tsfs_pkg::TickW'(SETTLE_TICKS);

  typedef enum logic [5:0] {
    PH_TRIG_LOW  = 6'b000001,
    PH_TRIG_HIGH = 6'b000010,
    PH_WAIT_ECHO = 6'b000100,
    PH_MEASURE   = 6'b001000,
    PH_PAUSE     = 6'b010000,
    PH_SETTLE    = 6'b100000
  } phase_t;

  phase_t                            phase, phase_next;
  logic [1:0]                        sensor_sel, sensor_sel_next;
  logic [tsfs_pkg::TickW-1:0]        tick_count, tick_count_next, tick_inc;
  logic [tsfs_pkg::DistW-1:0]        echo_count, echo_count_next, echo_inc;
  logic [tsfs_pkg::DistW-1:0]        dist_middle, dist_middle_next;
  logic [tsfs_pkg::DistW-1:0]        dist_left, dist_left_next;
  logic [tsfs_pkg::DistW-1:0]        dist_right, dist_right_next;
  logic [tsfs_pkg::PauseW-1:0]       pause_count, pause_count_next;
  tsfs_pkg::motor_t                  pins, pins_next;
  logic [tsfs_pkg::DutyW-1:0]        duty_a, duty_a_next;
  logic [tsfs_pkg::DutyW-1:0]        duty_b, duty_b_next;
  logic                              echo;
  logic                              decided;
  logic [tsfs_pkg::DistW-1:0]        dist_r_eff;
  tsfs_pkg::drive_t                  drive;

  // the right distance seen by the decision includes this clock's count
  assign dist_r_eff = (sensor_sel == tsfs_pkg::SelRight) ? echo_inc : dist_right;

  tsfs_decide u_decide (
    .cfg        (cfg),
    .dist_m     (dist_middle),
    .dist_l     (dist_left),
    .dist_r     (dist_r_eff),
    .pins_cur   (pins),
    .duty_a_cur (duty_a),
    .duty_b_cur (duty_b),
    .drive      (drive)
  );

  assign tick_inc = tick_count + tsfs_pkg::TickW'(1);
  assign echo_inc = echo_count + tsfs_pkg::DistW'(1);

  always_comb begin
    case (sensor_sel)
      tsfs_pkg::SelMiddle: echo = item.echo_middle;
      tsfs_pkg::SelLeft:   echo = item.echo_left;
      tsfs_pkg::SelRight:  echo = item.echo_right;
      default:             echo = 1'b0;
    endcase
  end

  always_comb begin
    phase_next       = phase;
    sensor_sel_next  = sensor_sel;
    tick_count_next  = tick_count;
    echo_count_next  = echo_count;
    dist_middle_next = dist_middle;
    dist_left_next   = dist_left;
    dist_right_next  = dist_right;
    pause_count_next = pause_count;
    pins_next        = pins;
    duty_a_next      = duty_a;
    duty_b_next      = duty_b;
    decided          = 1'b0;

    case (phase)
      PH_TRIG_LOW, PH_TRIG_HIGH: begin
        if (item.fine_tick) begin
          if (tick_inc >= TrigLim) begin
            tick_count_next = '0;
            phase_next = (phase == PH_TRIG_LOW) ? PH_TRIG_HIGH : PH_WAIT_ECHO;
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      PH_WAIT_ECHO: begin
        if (echo) begin
          phase_next      = PH_MEASURE;
          tick_count_next = '0;
          echo_count_next = '0;
        end
      end
      PH_MEASURE: begin
        if (item.fine_tick) begin
          if (tick_inc >= tsfs_pkg::UnitTicks) begin
            tick_count_next = '0;
            echo_count_next = echo_inc;
            // sample the echo at the end of each unit
            if (echo_inc >= cfg.range_limit || !echo) begin
              case (sensor_sel)
                tsfs_pkg::SelMiddle: begin
                  dist_middle_next = echo_inc;
                  sensor_sel_next  = tsfs_pkg::SelLeft;
                  phase_next       = PH_TRIG_LOW;
                end
                tsfs_pkg::SelLeft: begin
                  dist_left_next  = echo_inc;
                  sensor_sel_next = tsfs_pkg::SelRight;
                  phase_next      = PH_TRIG_LOW;
                end
                default: begin
                  if (sensor_sel == tsfs_pkg::SelRight) begin
                    dist_right_next = echo_inc;
                  end
                  pins_next        = drive.pins;
                  duty_a_next      = drive.duty_a;
                  duty_b_next      = drive.duty_b;
                  pause_count_next = drive.pause;
                  decided          = 1'b1;
                  phase_next = (drive.pause != tsfs_pkg::PauseNone) ? PH_PAUSE : PH_SETTLE;
                end
              endcase
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      PH_PAUSE: begin
        if (item.pause_tick) begin
          pause_count_next = pause_count - tsfs_pkg::PauseW'(1);
          if (pause_count_next == '0) begin
            phase_next      = PH_SETTLE;
            tick_count_next = '0;
          end
        end
      end
      PH_SETTLE: begin
        if (item.fine_tick) begin
          if (tick_inc >= SettleLim) begin
            tick_count_next = '0;
            sensor_sel_next = tsfs_pkg::SelMiddle;
            phase_next      = PH_TRIG_LOW;
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      default: begin
        phase_next      = PH_TRIG_LOW;
        sensor_sel_next = tsfs_pkg::SelMiddle;
        tick_count_next = '0;
      end
    endcase
  end

  always_comb begin
    res.trig_middle = (phase_next == PH_TRIG_HIGH) && (sensor_sel_next == tsfs_pkg::SelMiddle);
    res.trig_left   = (phase_next == PH_TRIG_HIGH) && (sensor_sel_next == tsfs_pkg::SelLeft);
    res.trig_right  = (phase_next == PH_TRIG_HIGH) && (sensor_sel_next == tsfs_pkg::SelRight);
    res.pins        = pins_next;
    res.duty_a      = duty_a_next;
    res.duty_b      = duty_b_next;
    res.decided     = decided;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TRIG_LOW;
      sensor_sel  <= tsfs_pkg::SelMiddle;
      tick_count  <= '0;
      echo_count  <= '0;
      dist_middle <= '0;
      dist_left   <= '0;
      dist_right  <= '0;
      pause_count <= '0;
      pins        <= '0;
      duty_a      <= '0;
      duty_b      <= '0;
    end else if (step) begin
      phase       <= phase_next;
      sensor_sel  <= sensor_sel_next;
      tick_count  <= tick_count_next;
      echo_count  <= echo_count_next;
      dist_middle <= dist_middle_next;
      dist_left   <= dist_left_next;
      dist_right  <= dist_right_next;
      pause_count <= pause_count_next;
      pins        <= pins_next;
      duty_a      <= duty_a_next;
      duty_b      <= duty_b_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/three_sonar_follow_sequencer_unit.sv
// Three-sensor sonar follow sequencer.
// Input stream (s_*): one request per sampled clock of the sensor side, carrying the
// fine and pause timer strobes and the three echo levels. The block ranges the middle,
// left and right sensors in turn, picks a drive action from the three distances and
// holds the motor pins and PWM duties until the next decision.
// Output stream (m_*): exactly one result per request: trigger lines, motor pins,
// duties and a decision strobe, all showing the state after that request.
// Configuration: write cfg_data to register cfg_index while cfg_wen is high; indexes
// past the last register are dropped. Write only while no request is in flight.
// Pipeline: an accepted request passes two register stages: the input register, then
// the sequencer step into the result register, taken once the output is free.
// Throughput: one request per cycle while results are taken, one sequencer step each.
// Stall: while m_tready is low the result holds; one more request is buffered in the
// input register, then s_tready drops until the result is taken.
// Reset (rst, synchronous): sequencer returns to trigger-low on the middle sensor,
// distances and counters clear, motors in standby with zero duty, registers to defaults,
// both stages empty.
`default_nettype none
module three_sonar_follow_sequencer_unit #(
  parameter int unsigned SETTLE_TICKS = tsfs_pkg::SettleTicksDefault,
  parameter int unsigned TRIG_TICKS   = tsfs_pkg::TrigTicksDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // fine_tick, pause_tick, echo_middle, echo_left, echo_right, 3 zero bits
  input  wire logic [7:0]                      s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // trig_middle, trig_left, trig_right, standby_n, a_in1, a_in2, b_in1, b_in2,
  // duty_a[4:0], duty_b[4:0], decided, 5 zero bits
  output logic [23:0]                          m_tdata,
  input  wire logic                            cfg_wen,
  input  wire logic [tsfs_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [tsfs_pkg::CfgDataW-1:0]   cfg_data
);

  tsfs_pkg::cfg_t     cfg;
  tsfs_pkg::in_item_t in_item;
  tsfs_pkg::res_t     res;
  logic               in_valid;
  logic               advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_limit   <= tsfs_pkg::DistW'(1);
      cfg.stop_limit   <= tsfs_pkg::DistW'(3);
      cfg.follow_limit <= tsfs_pkg::DistW'(10);
      cfg.drive_speed  <= tsfs_pkg::DutyW'(10);
      cfg.turn_speed   <= tsfs_pkg::DutyW'(7);
      cfg.range_limit  <= tsfs_pkg::DistW'(400);
    end else if (cfg_wen) begin
      case (cfg_index)
        tsfs_pkg::RegNearLimit:   cfg.near_limit   <= cfg_data;
        tsfs_pkg::RegStopLimit:   cfg.stop_limit   <= cfg_data;
        tsfs_pkg::RegFollowLimit: cfg.follow_limit <= cfg_data;
        tsfs_pkg::RegDriveSpeed:  cfg.drive_speed  <= cfg_data[tsfs_pkg::DutyW-1:0];
        tsfs_pkg::RegTurnSpeed:   cfg.turn_speed   <= cfg_data[tsfs_pkg::DutyW-1:0];
        tsfs_pkg::RegRangeLimit:  cfg.range_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[4:0];
    end
  end

  tsfs_core #(
    .SETTLE_TICKS (SETTLE_TICKS),
    .TRIG_TICKS   (TRIG_TICKS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'b0, res.decided, res.duty_b, res.duty_a,
                  res.pins.b_in2, res.pins.b_in1, res.pins.a_in2, res.pins.a_in1,
                  res.pins.standby_n, res.trig_right, res.trig_left, res.trig_middle};
    end
  end

endmodule
`default_nettype wire

FILE: sv/tsfs_checker.sv
`default_nettype none
module tsfs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // at most one sensor is triggered
  a_trig: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[2:0]))
    else $error("more than one trigger high");

  // enabled motors run in one consistent direction
  a_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |->
      (m_tdata[4] != m_tdata[5]) && (m_tdata[4] == m_tdata[7]) && (m_tdata[5] == m_tdata[6]))
    else $error("inconsistent motor direction pins");

  // a decision never coincides with a trigger pulse
  a_dec: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[2:0] == 3'b000)
    else $error("decision during trigger phase");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind three_sonar_follow_sequencer_unit tsfs_checker u_tsfs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
